FILE: rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types, constants and modular helpers for the power series divider.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int WORD_W       = 64;
    localparam int CNT_W        = 6;
    localparam int LEN_W        = 7;
    localparam int DEF_MAX_LEN  = 64;
    localparam int PADDR_W      = 5;

    localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(WORD_W - 1);

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_MODULUS = 2'd0;
    localparam logic [1:0] REG_NUM_LEN = 2'd1;
    localparam logic [1:0] REG_DEN_LEN = 2'd2;

    // Status codes of a result item.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOT_INV = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_DIV_STEP,
        DP_SAVE_A,
        DP_SAVE_B,
        DP_EU_DIV,
        DP_EU_MUL,
        DP_MUL_DBL,
        DP_MUL_ADD,
        DP_EU_NEXT,
        DP_EU_END,
        DP_S_CLR,
        DP_DOT_RD,
        DP_DOT_MUL,
        DP_DOT_ACC,
        DP_FIN_MUL,
        DP_FIN_WR,
        DP_ERR_WR,
        DP_OUT_Q,
        DP_OUT_ZERO
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   num_use;
        logic   den_use;
    } t_dp_cmd;

    typedef struct packed {
        logic r1_zero;
        logic r0_one;
    } t_dp_stat;

    // (a + b) mod m for a, b below m.
    function automatic logic [WORD_W-1:0] add_m(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b,
                                                input logic [WORD_W-1:0] m);
        logic [WORD_W-1:0] room;
        room = m - b;
        return (a >= room) ? (a - room) : (a + b);
    endfunction

    // (a - b) mod m for a, b below m.
    function automatic logic [WORD_W-1:0] sub_m(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b,
                                                input logic [WORD_W-1:0] m);
        return (a >= b) ? (a - b) : (a - b + m);
    endfunction

endpackage

FILE: rtl/psd_dp.sv
// ----------------------------------------------------------------------------
// psd_dp
// Datapath: bit-serial reducer and divider, bit-serial modular multiplier,
// extended Euclid registers, coefficient stores and the result register.
// ----------------------------------------------------------------------------
module psd_dp import psd_pkg::*; #(
    parameter int MAX_LEN = DEF_MAX_LEN,
    parameter int AW      = $clog2(MAX_LEN)
) (
    input  logic              i_clk,
    input  t_dp_cmd           i_cmd,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [AW-1:0]     i_rd_den_addr,
    input  logic [AW-1:0]     i_rd_quot_addr,
    input  logic [WORD_W-1:0] i_modulus,
    input  logic [WORD_W-1:0] i_num_coeff,
    input  logic [WORD_W-1:0] i_den_coeff,
    output t_dp_stat          o_stat,
    output logic [WORD_W-1:0] o_quotient_coeff
);

    logic [WORD_W-1:0] den_mem  [MAX_LEN];
    logic [WORD_W-1:0] quot_mem [MAX_LEN];

    logic [WORD_W-1:0] r_dvd, r_dvs, r_rem;
    logic [WORD_W-1:0] r_mx, r_my, r_macc;
    logic [WORD_W-1:0] r_r0, r_r1, r_t0, r_t1;
    logic [WORD_W-1:0] r_a, r_s, r_lead, r_q;
    logic [WORD_W-1:0] r_den_rd, r_quot_rd;

    logic [WORD_W-1:0] m_eff;
    logic [WORD_W:0]   div_part, div_diff;
    logic              div_take;
    logic [WORD_W-1:0] qq_red;

    assign m_eff = (i_modulus < WORD_W'(2)) ? WORD_W'(1) : i_modulus;

    // One restoring division step: shift in the next dividend bit and subtract.
    assign div_part = {r_rem, r_dvd[WORD_W-1]};
    assign div_diff = div_part - {1'b0, r_dvs};
    assign div_take = (div_part >= {1'b0, r_dvs});

    // Quotient of a Euclid step never exceeds the modulus.
    assign qq_red = (r_dvd >= m_eff) ? (r_dvd - m_eff) : r_dvd;

    assign o_stat.r1_zero = (r_r1 == '0);
    assign o_stat.r0_one  = (r_r0 == WORD_W'(1));
    assign o_quotient_coeff = r_q;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_dvd <= i_cmd.num_use ? i_num_coeff : '0;
                r_mx  <= i_cmd.den_use ? i_den_coeff : '0;
                r_dvs <= m_eff;
                r_rem <= '0;
            end
            DP_DIV_STEP: begin
                r_rem <= div_take ? div_diff[WORD_W-1:0] : div_part[WORD_W-1:0];
                r_dvd <= {r_dvd[WORD_W-2:0], div_take};
            end
            DP_SAVE_A: begin
                r_a   <= r_rem;
                r_dvd <= r_mx;
                r_dvs <= m_eff;
                r_rem <= '0;
            end
            DP_SAVE_B: begin
                r_r0 <= m_eff;
                r_r1 <= r_rem;
                r_t0 <= '0;
                r_t1 <= (m_eff == WORD_W'(1)) ? '0 : WORD_W'(1);
            end
            DP_EU_DIV: begin
                r_dvd <= r_r0;
                r_dvs <= r_r1;
                r_rem <= '0;
            end
            DP_EU_MUL: begin
                r_mx   <= qq_red;
                r_my   <= r_t1;
                r_macc <= '0;
            end
            DP_MUL_DBL: begin
                r_macc <= add_m(r_macc, r_macc, m_eff);
            end
            DP_MUL_ADD: begin
                if (r_my[WORD_W-1]) begin
                    r_macc <= add_m(r_macc, r_mx, m_eff);
                end
                r_my <= {r_my[WORD_W-2:0], 1'b0};
            end
            DP_EU_NEXT: begin
                r_r0 <= r_r1;
                r_r1 <= r_rem;
                r_t0 <= r_t1;
                r_t1 <= sub_m(r_t0, r_macc, m_eff);
            end
            DP_EU_END: begin
                r_lead <= (r_r0 == WORD_W'(1)) ? r_t0 : '0;
            end
            DP_S_CLR: begin
                r_s <= '0;
            end
            DP_DOT_RD: begin
                r_den_rd  <= den_mem[i_rd_den_addr];
                r_quot_rd <= quot_mem[i_rd_quot_addr];
            end
            DP_DOT_MUL: begin
                r_mx   <= r_den_rd;
                r_my   <= r_quot_rd;
                r_macc <= '0;
            end
            DP_DOT_ACC: begin
                r_s <= add_m(r_s, r_macc, m_eff);
            end
            DP_FIN_MUL: begin
                r_mx   <= sub_m(r_a, r_s, m_eff);
                r_my   <= r_lead;
                r_macc <= '0;
            end
            DP_OUT_Q: begin
                r_q <= r_macc;
            end
            DP_OUT_ZERO: begin
                r_q <= '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_SAVE_B) begin
            den_mem[i_wr_addr] <= r_rem;
        end
        if (i_cmd.op == DP_FIN_WR || i_cmd.op == DP_ERR_WR) begin
            quot_mem[i_wr_addr] <= (i_cmd.op == DP_FIN_WR) ? r_macc : '0;
        end
    end

endmodule

FILE: rtl/psd_ctrl.sv
// ----------------------------------------------------------------------------
// psd_ctrl
// Controller: sequences reduction, inversion, dot product and result hand-off.
// ----------------------------------------------------------------------------
module psd_ctrl import psd_pkg::*; #(
    parameter int MAX_LEN = DEF_MAX_LEN,
    parameter int AW      = $clog2(MAX_LEN),
    parameter int IW      = $clog2(MAX_LEN + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_first_coeff,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_status,
    input  logic [LEN_W-1:0] i_num_len,
    input  logic [LEN_W-1:0] i_den_len,
    input  t_dp_stat         i_stat,
    output t_dp_cmd          o_cmd,
    output logic [AW-1:0]    o_wr_addr,
    output logic [AW-1:0]    o_rd_den_addr,
    output logic [AW-1:0]    o_rd_quot_addr
);

    typedef enum logic [4:0] {
        S_IDLE, S_RED_A, S_SAVE_A, S_RED_B, S_SAVE_B, S_EU_CHK, S_EU_DIVL,
        S_EU_MUL, S_EU_NEXT, S_EU_END, S_MDBL, S_MADD, S_ERR, S_DOT_START,
        S_DOT_RD, S_DOT_MUL, S_DOT_ACC, S_FIN, S_FIN_WR, S_OUT
    } t_state;

    t_state            r_state, n_state, r_ret, n_ret;
    logic [IW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_j, n_j;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_err, n_err, r_zero, n_zero, r_ovalid, n_ovalid;
    logic [1:0]        r_stat, n_stat, r_pend, n_pend;
    logic [IW-1:0]     idx_eff;
    logic              out_free;

    assign idx_eff        = i_first_coeff ? '0 : r_idx;
    assign out_free       = !r_ovalid || i_out_ready;
    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_ovalid;
    assign o_status       = r_stat;
    assign o_wr_addr      = r_idx[AW-1:0];
    assign o_rd_den_addr  = r_j + AW'(1);
    assign o_rd_quot_addr = AW'(r_idx - IW'(1) - IW'(r_j));

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_idx   = r_idx;
        n_j     = r_j;
        n_cnt   = r_cnt;
        n_err   = r_err;
        n_zero  = r_zero;
        n_stat  = r_stat;
        n_pend  = r_pend;
        n_ovalid = (r_ovalid && !i_out_ready);
        o_cmd.op      = DP_NOP;
        o_cmd.num_use = (LEN_W'(idx_eff) < i_num_len);
        o_cmd.den_use = (LEN_W'(idx_eff) < i_den_len);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_idx = idx_eff;
                    if (i_first_coeff) begin
                        n_err = 1'b0;
                    end
                    if (idx_eff >= IW'(MAX_LEN)) begin
                        n_pend  = ST_TOO_LONG;
                        n_zero  = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        o_cmd.op = DP_LOAD;
                        n_cnt    = '0;
                        n_state  = S_RED_A;
                    end
                end
            end
            S_RED_A, S_RED_B, S_EU_DIVL: begin
                o_cmd.op = DP_DIV_STEP;
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == STEP_LAST) begin
                    n_state = (r_state == S_RED_A) ? S_SAVE_A :
                              (r_state == S_RED_B) ? S_SAVE_B : S_EU_MUL;
                end
            end
            S_SAVE_A: begin
                o_cmd.op = DP_SAVE_A;
                n_cnt    = '0;
                n_state  = S_RED_B;
            end
            S_SAVE_B: begin
                o_cmd.op = DP_SAVE_B;
                if (r_idx == '0) begin
                    n_state = S_EU_CHK;
                end else if (r_err) begin
                    n_state = S_ERR;
                end else begin
                    n_state = S_DOT_START;
                end
            end
            S_EU_CHK: begin
                if (i_stat.r1_zero) begin
                    n_state = S_EU_END;
                end else begin
                    o_cmd.op = DP_EU_DIV;
                    n_cnt    = '0;
                    n_state  = S_EU_DIVL;
                end
            end
            S_EU_MUL: begin
                o_cmd.op = DP_EU_MUL;
                n_cnt    = '0;
                n_ret    = S_EU_NEXT;
                n_state  = S_MDBL;
            end
            S_EU_NEXT: begin
                o_cmd.op = DP_EU_NEXT;
                n_state  = S_EU_CHK;
            end
            S_EU_END: begin
                o_cmd.op = DP_EU_END;
                if (!i_stat.r0_one) begin
                    n_err   = 1'b1;
                    n_state = S_ERR;
                end else begin
                    n_state = S_DOT_START;
                end
            end
            S_MDBL: begin
                o_cmd.op = DP_MUL_DBL;
                n_state  = S_MADD;
            end
            S_MADD: begin
                o_cmd.op = DP_MUL_ADD;
                n_cnt    = r_cnt + CNT_W'(1);
                n_state  = (r_cnt == STEP_LAST) ? r_ret : S_MDBL;
            end
            S_ERR: begin
                o_cmd.op = DP_ERR_WR;
                n_pend   = ST_NOT_INV;
                n_zero   = 1'b1;
                n_idx    = r_idx + IW'(1);
                n_state  = S_OUT;
            end
            S_DOT_START: begin
                o_cmd.op = DP_S_CLR;
                n_j      = '0;
                n_state  = (r_idx == '0) ? S_FIN : S_DOT_RD;
            end
            S_DOT_RD: begin
                o_cmd.op = DP_DOT_RD;
                n_state  = S_DOT_MUL;
            end
            S_DOT_MUL: begin
                o_cmd.op = DP_DOT_MUL;
                n_cnt    = '0;
                n_ret    = S_DOT_ACC;
                n_state  = S_MDBL;
            end
            S_DOT_ACC: begin
                o_cmd.op = DP_DOT_ACC;
                n_j      = r_j + AW'(1);
                n_state  = (IW'(r_j) + IW'(1) == r_idx) ? S_FIN : S_DOT_RD;
            end
            S_FIN: begin
                o_cmd.op = DP_FIN_MUL;
                n_cnt    = '0;
                n_ret    = S_FIN_WR;
                n_state  = S_MDBL;
            end
            S_FIN_WR: begin
                o_cmd.op = DP_FIN_WR;
                n_pend   = ST_OK;
                n_zero   = 1'b0;
                n_idx    = r_idx + IW'(1);
                n_state  = S_OUT;
            end
            S_OUT: begin
                // The status moves to the output register together with the
                // quotient, so a result still waiting keeps its own status.
                if (out_free) begin
                    o_cmd.op = r_zero ? DP_OUT_ZERO : DP_OUT_Q;
                    n_stat   = r_pend;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_idx    <= '0;
            r_j      <= '0;
            r_cnt    <= '0;
            r_err    <= 1'b0;
            r_zero   <= 1'b0;
            r_stat   <= ST_OK;
            r_pend   <= ST_OK;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_idx    <= n_idx;
            r_j      <= n_j;
            r_cnt    <= n_cnt;
            r_err    <= n_err;
            r_zero   <= n_zero;
            r_stat   <= n_stat;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

FILE: rtl/power_series_division_mod.sv
// ----------------------------------------------------------------------------
// power_series_division_mod
// Truncated power series division modulo a 64-bit integer, one coefficient
// of numerator and denominator in and one quotient coefficient out per item.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                        Direction
//  input     i_in_valid/o_in_ready, first/num/den coeff     in
//  output    o_out_valid/i_out_ready, quotient, status      out
//  config    psel/penable/pwrite/paddr/pwdata/prdata/pready in/out
//
// An item at index i runs two bit-serial reductions of the inputs, then
// i multiply-accumulate steps of the dot product, each a bit-serial
// modular multiply, and a final multiply by the leading inverse. Index
// zero also runs the extended Euclid inversion. All of these share the
// single serial multiplier. Items at or beyond MAX_LEN skip the work and
// answer with a zero quotient and the too-long status.
// Reset is synchronous and clears control state and config registers; the
// coefficient stores are not cleared. The finished result sits in an output
// register, so a new item is taken while it waits on a stalled consumer.
//
module power_series_division_mod import psd_pkg::*; #(
    parameter int MAX_LEN = DEF_MAX_LEN
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_first_coeff,
    input  logic [WORD_W-1:0]  i_num_coeff,
    input  logic [WORD_W-1:0]  i_den_coeff,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [WORD_W-1:0]  o_quotient_coeff,
    output logic [1:0]         o_status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0]  pwdata,
    output logic [WORD_W-1:0]  prdata,
    output logic               pready
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int IW = $clog2(MAX_LEN + 1);

    logic [WORD_W-1:0] r_modulus;
    logic [LEN_W-1:0]  r_num_len, r_den_len;
    logic [1:0]        reg_sel;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic [AW-1:0] wr_addr, rd_den_addr, rd_quot_addr;

    // Registers sit on 8-byte boundaries since the modulus is 64 bits wide.
    assign reg_sel = paddr[4:3];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= WORD_W'(2);
            r_num_len <= LEN_W'(64);
            r_den_len <= LEN_W'(64);
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                REG_MODULUS: r_modulus <= pwdata;
                REG_NUM_LEN: r_num_len <= pwdata[LEN_W-1:0];
                REG_DEN_LEN: r_den_len <= pwdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_MODULUS: prdata = r_modulus;
            REG_NUM_LEN: prdata = WORD_W'(r_num_len);
            REG_DEN_LEN: prdata = WORD_W'(r_den_len);
            default:     prdata = '0;
        endcase
    end

    // The controller steps through the schedule; the datapath does the math.
    psd_ctrl #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW),
        .IW      (IW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_first_coeff  (i_first_coeff),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .i_num_len      (r_num_len),
        .i_den_len      (r_den_len),
        .i_stat         (stat),
        .o_cmd          (cmd),
        .o_wr_addr      (wr_addr),
        .o_rd_den_addr  (rd_den_addr),
        .o_rd_quot_addr (rd_quot_addr)
    );

    psd_dp #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW)
    ) u_dp (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .i_wr_addr        (wr_addr),
        .i_rd_den_addr    (rd_den_addr),
        .i_rd_quot_addr   (rd_quot_addr),
        .i_modulus        (r_modulus),
        .i_num_coeff      (i_num_coeff),
        .i_den_coeff      (i_den_coeff),
        .o_stat           (stat),
        .o_quotient_coeff (o_quotient_coeff)
    );

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the modular power series divider. Items are
// predicted at acceptance from a local model of the coefficient stores, the
// leading inverse and the run index, then matched in order against results.
// ----------------------------------------------------------------------------
module tb;
    import psd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN     = DEF_MAX_LEN;
    localparam int ITEM_TARGET = 1900;
    localparam int CALM_ITEMS  = 200;      // final stretch with no idling
    localparam int STALL_LIMIT = 200000;   // Euclid on 64 bits plus a deep dot product
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TOP_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_first_coeff = 1'b0;
    logic [WORD_W-1:0]  i_num_coeff = '0;
    logic [WORD_W-1:0]  i_den_coeff = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [WORD_W-1:0]  o_quotient_coeff;
    logic [1:0]         o_status;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [WORD_W-1:0]  pwdata = '0;
    logic [WORD_W-1:0]  prdata;
    logic               pready;

    power_series_division_mod #(.MAX_LEN(MAX_LEN)) u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // One expected result item.
    typedef struct {
        logic [63:0] quot;
        logic [1:0]  status;
    } t_quot_result;

    // A row of the directed table. When load_cfg is set, the bench drains the
    // block and writes all three registers before sending the item.
    typedef struct {
        bit          load_cfg;
        logic [63:0] modulus;
        logic [6:0]  num_len;
        logic [6:0]  den_len;
        bit          first;
        logic [63:0] num;
        logic [63:0] den;
        bit          typed;
        logic [63:0] quot;
        logic [1:0]  status;
    } t_dir_row;

    t_quot_result expected_quots[$];
    int           mismatches = 0;
    int           items_sent = 0;
    int           quiet_cycles = 0;
    bit           idle_on = 1'b0;

    // Register shadow, tracked from the writes actually seen on the port.
    logic [63:0] cfg_modulus = 64'd2;
    logic [6:0]  cfg_num_len = 7'd64;
    logic [6:0]  cfg_den_len = 7'd64;

    // Series state of the local model.
    logic [63:0] den_mem [MAX_LEN];
    logic [63:0] quot_mem [MAX_LEN];
    logic [63:0] lead_inv = '0;
    int          run_idx = 0;
    bit          run_err = 1'b0;

    // The directed row in flight, if its result is typed in by hand.
    bit          drv_typed = 1'b0;
    logic [63:0] drv_quot = '0;
    logic [1:0]  drv_status = ST_OK;

    // ------------------------------------------------------------------
    // Modular arithmetic, done with wide intermediates.
    // ------------------------------------------------------------------
    function automatic logic [63:0] mod_add(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return 64'(s % {1'b0, m});
    endfunction

    function automatic logic [63:0] mod_sub(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, m} - {1'b0, b};
        return 64'(s % {1'b0, m});
    endfunction

    function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return 64'(p % {64'd0, m});
    endfunction

    // Extended Euclid; returns 1 with the inverse when gcd(a, m) is one.
    function automatic bit mod_invert(logic [63:0] a, logic [63:0] m, output logic [63:0] inv);
        logic [63:0] r0, r1, r2, t0, t1, t2, qq;
        r0 = m;
        r1 = a;
        t0 = '0;
        t1 = 64'd1 % m;
        while (r1 != 0) begin
            qq = r0 / r1;
            r2 = r0 - qq * r1;
            t2 = mod_sub(t0, mod_mul(qq % m, t1, m), m);
            r0 = r1;
            r1 = r2;
            t0 = t1;
            t1 = t2;
        end
        inv = (r0 == 64'd1) ? t0 : '0;
        return r0 == 64'd1;
    endfunction

    // Quotient coefficient for one accepted item; advances the series state.
    task automatic predict_quot(input logic first, input logic [63:0] num,
                                input logic [63:0] den, output t_quot_result res);
        logic [63:0] m, a, b, acc;
        m = (cfg_modulus < 64'd2) ? 64'd1 : cfg_modulus;
        if (first) begin
            run_idx = 0;
            run_err = 1'b0;
        end
        if (run_idx >= MAX_LEN) begin
            // Too long wins over a bad leading coefficient; index stays put.
            res.quot = '0;
            res.status = ST_TOO_LONG;
            return;
        end
        a = (run_idx < int'(cfg_num_len)) ? num % m : '0;
        b = (run_idx < int'(cfg_den_len)) ? den % m : '0;
        den_mem[run_idx] = b;
        if (run_idx == 0)
            run_err = !mod_invert(b, m, lead_inv);
        if (run_err) begin
            quot_mem[run_idx] = '0;
            run_idx++;
            res.quot = '0;
            res.status = ST_NOT_INV;
            return;
        end
        acc = '0;
        for (int k = 0; k < run_idx; k++)
            acc = mod_add(acc, mod_mul(den_mem[k + 1], quot_mem[run_idx - 1 - k], m), m);
        res.quot = mod_mul(mod_sub(a, acc, m), lead_inv, m);
        res.status = ST_OK;
        quot_mem[run_idx] = res.quot;
        run_idx++;
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("mismatch on %s: expected %h, got %h at %0t", field, want, got, $realtime);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted input item, checks every result
    // item, shadows register writes and runs the watchdog. All of it is
    // sampled at the rising edge, before the block's own updates land.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_quot_result res, want;
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready) begin
                moved = 1'b1;
                case (paddr[4:3])
                    REG_MODULUS: cfg_modulus = pwdata;
                    REG_NUM_LEN: cfg_num_len = pwdata[6:0];
                    REG_DEN_LEN: cfg_den_len = pwdata[6:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                moved = 1'b1;
                predict_quot(i_first_coeff, i_num_coeff, i_den_coeff, res);
                if (drv_typed) begin
                    res.quot = drv_quot;
                    res.status = drv_status;
                end
                expected_quots.push_back(res);
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (expected_quots.size() == 0) begin
                    report_mismatch("unexpected item", '0, o_quotient_coeff);
                end else begin
                    want = expected_quots.pop_front();
                    if (o_quotient_coeff !== want.quot)
                        report_mismatch("quotient_coeff", want.quot, o_quotient_coeff);
                    if (o_status !== want.status)
                        report_mismatch("status", 64'(want.status), 64'(o_status));
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Result side: random stall bursts while idling is enabled.
    always @(negedge i_clk) begin : out_stall
        int stall_left;
        if (!idle_on) begin
            stall_left = 0;
            i_out_ready = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready = 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 14);
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks. Everything changes at the falling edge.
    // ------------------------------------------------------------------
    task automatic send_item(input bit first, input logic [63:0] num, input logic [63:0] den,
                             input bit typed, input logic [63:0] quot, input logic [1:0] status);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_first_coeff = first;
        i_num_coeff = num;
        i_den_coeff = den;
        drv_typed = typed;
        drv_quot = quot;
        drv_status = status;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        items_sent++;
    endtask

    // Stops sending and waits until every expected result has come back.
    task automatic drain;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        drv_typed = 1'b0;
        while (expected_quots.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 3'b000};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic load_config(input logic [63:0] modulus, input logic [6:0] num_len,
                               input logic [6:0] den_len);
        drain();
        write_reg(REG_MODULUS, modulus);
        write_reg(REG_NUM_LEN, {57'd0, num_len});
        write_reg(REG_DEN_LEN, {57'd0, den_len});
    endtask

    function automatic logic [63:0] pick_modulus();
        case ($urandom_range(0, 9))
            0, 1, 2: return 64'($urandom_range(2, 255));
            3, 4:    return 64'($urandom_range(2, 65535));
            5:       return {32'd0, $urandom} | 64'd1;
            6:       return {$urandom, $urandom};
            7:       return ($urandom_range(0, 1) != 0) ? ALL_ONES : TOP_PRIME;
            8:       return 64'($urandom_range(0, 1));
            default: return 64'd1 << $urandom_range(1, 63);
        endcase
    endfunction

    function automatic logic [6:0] pick_len();
        case ($urandom_range(0, 7))
            0:       return 7'($urandom_range(0, 64));
            1:       return 7'($urandom_range(65, 127));
            2:       return 7'($urandom_range(0, 1));
            default: return 7'd64;
        endcase
    endfunction

    // Mostly reduced coefficients, with some unreduced and extreme ones.
    function automatic logic [63:0] pick_coeff(input logic [63:0] m);
        logic [63:0] mm;
        mm = (m < 64'd2) ? 64'd1 : m;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return mm - 64'd1;
            2:       return ALL_ONES;
            3:       return {$urandom, $urandom};
            4:       return 64'($urandom_range(0, 15));
            default: return {$urandom, $urandom} % mm;
        endcase
    endfunction

    t_dir_row dir_rows [19] = '{
        // After reset: modulus 2, no start mark on the very first item.
        '{0, 0, 0, 0, 0, 64'd1, 64'd1, 1, 64'd1, ST_OK},
        '{0, 0, 0, 0, 0, 64'd0, 64'd1, 0, 0, ST_OK},
        '{0, 0, 0, 0, 1, ALL_ONES, ALL_ONES, 1, 64'd1, ST_OK},
        '{0, 0, 0, 0, 1, 64'd0, 64'd0, 1, 0, ST_NOT_INV},
        '{0, 0, 0, 0, 0, 64'd1, 64'd1, 1, 0, ST_NOT_INV},
        // Modulus zero and one behave as one: every quotient is zero.
        '{1, 64'd0, 7'd64, 7'd64, 1, 64'd5, 64'd3, 1, 0, ST_OK},
        '{1, 64'd1, 7'd64, 7'd64, 1, 64'd5, 64'd3, 1, 0, ST_OK},
        // Widest modulus.
        '{1, ALL_ONES, 7'd64, 7'd64, 1, ALL_ONES - 1, 64'd1, 1, ALL_ONES - 1, ST_OK},
        '{0, 0, 0, 0, 0, ALL_ONES, ALL_ONES, 0, 0, ST_OK},
        '{0, 0, 0, 0, 0, 64'd12345, 64'h8000_0000_0000_0000, 0, 0, ST_OK},
        '{0, 0, 0, 0, 1, 64'd7, 64'd3, 1, 0, ST_NOT_INV},
        // Zero lengths: numerator dropped, then the leading denominator.
        '{1, 64'd97, 7'd0, 7'd64, 1, 64'd5, 64'd1, 1, 0, ST_OK},
        '{1, 64'd97, 7'd64, 7'd0, 1, 64'd5, 64'd1, 1, 0, ST_NOT_INV},
        // Short lengths cut the series off after a few coefficients.
        '{1, 64'd97, 7'd2, 7'd1, 1, 64'd3, 64'd2, 0, 0, ST_OK},
        '{0, 0, 0, 0, 0, 64'd96, 64'd96, 0, 0, ST_OK},
        '{0, 0, 0, 0, 0, 64'd50, 64'd50, 0, 0, ST_OK},
        '{1, TOP_PRIME, 7'd127, 7'd127, 1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
          0, 0, ST_OK},
        '{0, 0, 0, 0, 0, ALL_ONES, ALL_ONES, 0, 0, ST_OK},
        // Even lead under a power-of-two modulus.
        '{1, 64'h8000_0000_0000_0000, 7'd64, 7'd64, 1, 64'd1, 64'd2, 1, 0, ST_NOT_INV}
    };

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int run_len;
        int phase_items;
        bit long_done;
        bit first;

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows run without idling so the typed results line up simply.
        foreach (dir_rows[r]) begin
            if (dir_rows[r].load_cfg)
                load_config(dir_rows[r].modulus, dir_rows[r].num_len, dir_rows[r].den_len);
            send_item(dir_rows[r].first, dir_rows[r].num, dir_rows[r].den,
                      dir_rows[r].typed, dir_rows[r].quot, dir_rows[r].status);
        end

        // Random phases: each starts from an idle block with a fresh setting.
        // Draining for the new setting is also where the sender waits out
        // every outstanding result.
        long_done = 1'b0;
        while (items_sent < ITEM_TARGET) begin
            load_config(pick_modulus(), pick_len(), pick_len());
            idle_on = (items_sent < ITEM_TARGET - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
            phase_items = 0;
            while (phase_items < 200 && items_sent < ITEM_TARGET) begin
                case ($urandom_range(0, 99))
                    0:                       run_len = $urandom_range(65, 70);
                    1, 2, 3, 4, 5, 6, 7, 8:  run_len = $urandom_range(9, 24);
                    default:                 run_len = $urandom_range(1, 8);
                endcase
                // Make sure one series runs past the maximum length early on.
                if (!long_done) begin
                    run_len = MAX_LEN + 3;
                    long_done = 1'b1;
                end
                for (int n = 0; n < run_len; n++) begin
                    // The final stretch runs with no idling on either side.
                    if (items_sent >= ITEM_TARGET - CALM_ITEMS)
                        idle_on = 1'b0;
                    // Occasional stray start marks break a short series in the
                    // middle; long series are left whole to run past the end.
                    first = (n == 0) ||
                            ((run_len <= MAX_LEN) && ($urandom_range(0, 39) == 0));
                    send_item(first, pick_coeff(cfg_modulus), pick_coeff(cfg_modulus),
                              0, '0, ST_OK);
                    phase_items++;
                end
            end
        end

        drain();
        repeat (50) @(negedge i_clk);
        if (mismatches == 0 && expected_quots.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
